/* hdl/hst_pkg.sv */
`timescale 1ns / 1ps

package hst_pkg;

    localparam int IN_DATA_W  = 200;
    localparam int OUT_DATA_W = 152;
    localparam int KIND_W     = 2;
    localparam int CFG_W      = 9;

    localparam logic [1:0] KIND_INSERT   = 2'd0;
    localparam logic [1:0] KIND_GET      = 2'd1;
    localparam logic [1:0] KIND_REMOVE   = 2'd2;
    localparam logic [1:0] KIND_READJUST = 2'd3;

    localparam logic [1:0] RES_OK    = 2'd0;
    localparam logic [1:0] RES_FULL  = 2'd1;
    localparam logic [1:0] RES_RANGE = 2'd2;

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic rd_key;
        logic rm_key;
        logic get_cap;
        logic set_full;
        logic set_range;
        logic out_load;
    } hst_cmd_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       key_ok;
        logic       n_zero;
        logic       chk_vld;
        logic       chk_zero;
        logic       chk_last;
        logic       clr_last;
        logic       out_free;
    } hst_sts_t;

endpackage

/* hdl/handle_slot_table.sv */
`timescale 1ns / 1ps

// channel   direction  handshake            payload
// s_        in         s_tvalid / s_tready  s_tuser kind, s_tdata request fields
// m_        out        m_tvalid / m_tready  m_tdata result fields
// cfg_      in         cfg_valid / cfg_ready  cfg_data slots_in_use
//
// one request at a time; insert and readjust read one slot per cycle through the
// single read port of the slot memory
// every request stalls while the output register is full
// after reset a clearing pass writes every slot, with s_tready low
// cfg_ready is always high

module handle_slot_table
    import hst_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // kind
    input  logic [KIND_W-1:0]     s_tuser,
    // object_address, owner_tag, slot_index, adjustment
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // result_index, result_tag, result_address, adjusted_count, status, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_W-1:0]      cfg_data
);

    hst_cmd_t cmd;
    hst_sts_t sts;

    assign cfg_ready = 1'b1;

    hst_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    hst_datapath #(
        .SLOTS (SLOTS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .m_tready  (m_tready),
        .m_tvalid  (m_tvalid),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

/* hdl/hst_ctrl.sv */
`timescale 1ns / 1ps

module hst_ctrl
    import hst_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_tvalid,
    output logic     s_tready,
    input  hst_sts_t sts,
    output hst_cmd_t cmd
);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_DISPATCH = 3'd2;
    localparam logic [2:0] S_GET_WAIT = 3'd3;
    localparam logic [2:0] S_SCAN     = 3'd4;
    localparam logic [2:0] S_DONE     = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_CLEAR: begin
                cmd.clear = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                case (sts.kind)
                    KIND_INSERT: begin
                        if (sts.n_zero) begin
                            cmd.set_full = 1'b1;
                            state_next   = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    KIND_GET: begin
                        if (sts.key_ok) begin
                            cmd.rd_key = 1'b1;
                            state_next = S_GET_WAIT;
                        end else begin
                            cmd.set_range = 1'b1;
                            state_next    = S_DONE;
                        end
                    end
                    KIND_REMOVE: begin
                        if (sts.key_ok) begin
                            cmd.rm_key = 1'b1;
                        end else begin
                            cmd.set_range = 1'b1;
                        end
                        state_next = S_DONE;
                    end
                    default: begin
                        if (sts.n_zero) begin
                            state_next = S_DONE;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end
            S_GET_WAIT: begin
                cmd.get_cap = 1'b1;
                state_next  = S_DONE;
            end
            S_SCAN: begin
                cmd.scan = 1'b1;
                if (sts.chk_vld) begin
                    if (sts.kind == KIND_INSERT) begin
                        if (sts.chk_zero || sts.chk_last) begin
                            state_next = S_DONE;
                        end
                    end else if (sts.chk_last) begin
                        state_next = S_DONE;
                    end
                end
            end
            S_DONE: begin
                if (sts.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* hdl/hst_datapath.sv */
`timescale 1ns / 1ps

module hst_datapath
    import hst_pkg::*;
#(
    parameter int SLOTS = 256
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic [KIND_W-1:0]     s_tuser,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  cfg_valid,
    input  logic [CFG_W-1:0]      cfg_data,
    input  logic                  m_tready,
    output logic                  m_tvalid,
    output logic [OUT_DATA_W-1:0] m_tdata,
    input  hst_cmd_t              cmd,
    output hst_sts_t              sts
);

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int N_W   = ($clog2(SLOTS + 1) > 9) ? $clog2(SLOTS + 1) : 9;

    logic [CFG_W-1:0] cfg_slots_reg;

    logic [1:0]  kind_reg;
    logic [63:0] obj_addr_reg;
    logic [63:0] tag_reg;
    logic [7:0]  key_reg;
    logic [63:0] adj_reg;

    logic [N_W-1:0]   issue_cnt_reg;
    logic [IDX_W-1:0] chk_idx_reg;
    logic             chk_vld_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    logic [63:0] mem_addr [SLOTS];
    logic [63:0] mem_own  [SLOTS];
    logic [63:0] rd_addr_reg;
    logic [63:0] rd_own_reg;

    logic [7:0]  res_index_reg;
    logic [63:0] res_tag_reg;
    logic [63:0] res_addr_reg;
    logic [8:0]  res_count_reg;
    logic [1:0]  res_status_reg;

    logic                  m_tvalid_reg;
    logic [OUT_DATA_W-1:0] m_tdata_reg;

    logic [N_W-1:0]   n_act;
    logic             issue_more;
    logic             chk_zero;
    logic             chk_match;
    logic             we;
    logic [IDX_W-1:0] wa;
    logic [63:0]      wd_addr;
    logic [63:0]      wd_own;
    logic             re;
    logic [IDX_W-1:0] ra;

    assign n_act = (N_W'(cfg_slots_reg) < N_W'(SLOTS)) ? N_W'(cfg_slots_reg) : N_W'(SLOTS);
    assign issue_more = issue_cnt_reg < n_act;
    assign chk_zero   = (rd_addr_reg == 64'd0);
    assign chk_match  = (rd_own_reg == tag_reg);

    assign sts.kind     = kind_reg;
    assign sts.key_ok   = N_W'(key_reg) < n_act;
    assign sts.n_zero   = (n_act == '0);
    assign sts.chk_vld  = chk_vld_reg;
    assign sts.chk_zero = chk_zero;
    assign sts.chk_last = ((N_W'(chk_idx_reg) + N_W'(1)) == n_act);
    assign sts.clr_last = (clr_idx_reg == IDX_W'(SLOTS - 1));
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // memory port selection
    always_comb begin
        we      = 1'b0;
        wa      = chk_idx_reg;
        wd_addr = 64'd0;
        wd_own  = 64'd0;
        re      = 1'b0;
        ra      = issue_cnt_reg[IDX_W-1:0];
        if (cmd.clear) begin
            we = 1'b1;
            wa = clr_idx_reg;
        end
        if (cmd.rm_key) begin
            we = 1'b1;
            wa = IDX_W'(key_reg);
        end
        if (cmd.rd_key) begin
            re = 1'b1;
            ra = IDX_W'(key_reg);
        end
        if (cmd.scan) begin
            re = issue_more;
            if (chk_vld_reg) begin
                if (kind_reg == KIND_INSERT) begin
                    if (chk_zero) begin
                        we      = 1'b1;
                        wd_addr = obj_addr_reg;
                        wd_own  = tag_reg;
                    end
                end else if (chk_match) begin
                    we      = 1'b1;
                    wd_addr = rd_addr_reg - adj_reg;
                    wd_own  = rd_own_reg;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_addr[wa] <= wd_addr;
            mem_own[wa]  <= wd_own;
        end
        if (re) begin
            rd_addr_reg <= mem_addr[ra];
            rd_own_reg  <= mem_own[ra];
        end
    end

    // payload and results
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            kind_reg       <= s_tuser;
            obj_addr_reg   <= s_tdata[63:0];
            tag_reg        <= s_tdata[127:64];
            key_reg        <= s_tdata[135:128];
            adj_reg        <= s_tdata[199:136];
            res_index_reg  <= 8'd0;
            res_tag_reg    <= 64'd0;
            res_addr_reg   <= 64'd0;
            res_count_reg  <= 9'd0;
            res_status_reg <= RES_OK;
        end
        if (cmd.scan) begin
            chk_idx_reg <= issue_cnt_reg[IDX_W-1:0];
            if (chk_vld_reg) begin
                if (kind_reg == KIND_INSERT) begin
                    if (chk_zero) begin
                        res_index_reg <= 8'(chk_idx_reg);
                        res_tag_reg   <= tag_reg;
                    end else if (sts.chk_last) begin
                        res_status_reg <= RES_FULL;
                    end
                end else if (chk_match) begin
                    res_count_reg <= res_count_reg + 9'd1;
                end
            end
        end
        if (cmd.set_full) begin
            res_status_reg <= RES_FULL;
        end
        if (cmd.set_range) begin
            res_status_reg <= RES_RANGE;
        end
        if (cmd.get_cap) begin
            res_addr_reg <= rd_addr_reg;
        end
        if (cmd.out_load) begin
            m_tdata_reg <= {5'd0, res_status_reg, res_count_reg, res_addr_reg,
                            res_tag_reg, res_index_reg};
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_slots_reg <= '0;
            issue_cnt_reg <= '0;
            chk_vld_reg   <= 1'b0;
            clr_idx_reg   <= '0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_valid) begin
                cfg_slots_reg <= cfg_data;
            end
            if (cmd.clear) begin
                clr_idx_reg <= clr_idx_reg + IDX_W'(1);
            end
            if (cmd.load) begin
                issue_cnt_reg <= '0;
                chk_vld_reg   <= 1'b0;
            end else if (cmd.scan) begin
                chk_vld_reg <= issue_more;
                if (issue_more) begin
                    issue_cnt_reg <= issue_cnt_reg + N_W'(1);
                end
            end
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

endmodule

/* bench/tb_handle_slot_table.sv */
`timescale 1ns / 1ps

module tb_handle_slot_table
    import hst_pkg::*;
;
    localparam int SLOTS = 256;
    localparam int CYCLE_LIMIT = 3_000_000;
    localparam logic [63:0] TAG_MIN = 64'h8000_0000_0000_0000;
    localparam logic [63:0] TAG_MAX = 64'h7fff_ffff_ffff_ffff;
    localparam logic [63:0] ALL_ONES = '1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [63:0] addr;
        logic [63:0] tag;
        logic [7:0]  key;
        logic [63:0] adj;
    } table_op_t;

    typedef struct packed {
        logic [7:0]  index;
        logic [63:0] tag;
        logic [63:0] addr;
        logic [8:0]  count;
        logic [1:0]  status;
    } table_reply_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [KIND_W-1:0]     s_tuser = '0;
    logic [IN_DATA_W-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_W-1:0]      cfg_data = '0;

    table_op_t    queued_ops[$];
    table_reply_t predicted_replies[$];
    table_op_t    op_in_flight;
    logic [63:0]  slot_addr[SLOTS];
    logic [63:0]  slot_tag[SLOTS];
    logic [8:0]   slot_limit = '0;
    int           ops_issued = 0;
    int           ops_accepted = 0;
    int           err_count = 0;
    int           src_wait = 0;
    int           sink_wait = 0;
    bit           src_steady = 1'b0;
    bit           sink_steady = 1'b0;
    int           cycle_count;

    handle_slot_table #(
        .SLOTS(SLOTS)
    ) u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #5 aclk = ~aclk;

    function automatic int active_slots();
        return (slot_limit > SLOTS) ? SLOTS : int'(slot_limit);
    endfunction

    function automatic table_reply_t apply_table_op(input table_op_t op);
        table_reply_t rp;
        int n;
        int i;
        rp = '0;
        n = active_slots();
        case (op.kind)
            KIND_INSERT: begin
                i = 0;
                while (i < n && slot_addr[i] != 64'd0)
                    i++;
                if (i >= n) begin
                    rp.status = RES_FULL;
                end else begin
                    slot_addr[i] = op.addr;
                    slot_tag[i] = op.tag;
                    rp.index = i[7:0];
                    rp.tag = op.tag;
                end
            end
            KIND_GET: begin
                if (op.key < n)
                    rp.addr = slot_addr[op.key];
                else
                    rp.status = RES_RANGE;
            end
            KIND_REMOVE: begin
                if (op.key < n) begin
                    slot_addr[op.key] = 64'd0;
                    slot_tag[op.key] = 64'd0;
                end else begin
                    rp.status = RES_RANGE;
                end
            end
            default: begin
                for (i = 0; i < n; i++) begin
                    if (slot_tag[i] == op.tag) begin
                        slot_addr[i] = slot_addr[i] - op.adj;
                        rp.count = rp.count + 9'd1;
                    end
                end
            end
        endcase
        return rp;
    endfunction

    function automatic int pick_gap(input bit steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // source side
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            src_wait <= 0;
        end else begin
            if (s_tvalid && s_tready) begin
                predicted_replies.push_back(apply_table_op(op_in_flight));
                ops_accepted++;
            end
            if (s_tvalid && !s_tready) begin
                s_tvalid <= 1'b1;
            end else if (src_wait > 0) begin
                s_tvalid <= 1'b0;
                src_wait <= src_wait - 1;
            end else if (queued_ops.size() > 0) begin
                op_in_flight = queued_ops.pop_front();
                s_tvalid <= 1'b1;
                s_tuser <= op_in_flight.kind;
                s_tdata <= {op_in_flight.adj, op_in_flight.key, op_in_flight.tag,
                            op_in_flight.addr};
                src_wait <= pick_gap(src_steady);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result side
    always @(posedge aclk) begin
        table_reply_t got;
        table_reply_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            sink_wait <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got.index = m_tdata[7:0];
                got.tag = m_tdata[71:8];
                got.addr = m_tdata[135:72];
                got.count = m_tdata[144:136];
                got.status = m_tdata[146:145];
                if (predicted_replies.size() == 0) begin
                    $error("result transaction with no prediction pending");
                    err_count++;
                end else begin
                    want = predicted_replies.pop_front();
                    if (got.index !== want.index) begin
                        $error("result_index expected %0d got %0d", want.index, got.index);
                        err_count++;
                    end
                    if (got.tag !== want.tag) begin
                        $error("result_tag expected %h got %h", want.tag, got.tag);
                        err_count++;
                    end
                    if (got.addr !== want.addr) begin
                        $error("result_address expected %h got %h", want.addr, got.addr);
                        err_count++;
                    end
                    if (got.count !== want.count) begin
                        $error("adjusted_count expected %0d got %0d", want.count, got.count);
                        err_count++;
                    end
                    if (got.status !== want.status) begin
                        $error("status expected %0d got %0d", want.status, got.status);
                        err_count++;
                    end
                end
            end
            if (sink_wait > 0) begin
                m_tready <= 1'b0;
                sink_wait <= sink_wait - 1;
            end else begin
                m_tready <= 1'b1;
                if (m_tvalid && m_tready)
                    sink_wait <= pick_gap(sink_steady);
            end
        end
    end

    task automatic queue_op(input logic [1:0] kind, input logic [63:0] addr,
                            input logic [63:0] tag, input logic [7:0] key,
                            input logic [63:0] adj);
        table_op_t op;
        op.kind = kind;
        op.addr = addr;
        op.tag = tag;
        op.key = key;
        op.adj = adj;
        queued_ops.push_back(op);
        ops_issued++;
    endtask

    task automatic drain();
        while (ops_accepted != ops_issued || predicted_replies.size() != 0)
            @(posedge aclk);
    endtask

    task automatic write_slot_limit(input logic [8:0] value);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        slot_limit = value;
        cfg_valid <= 1'b0;
    endtask

    task automatic random_ops(input int count);
        logic [63:0] tag_pool[4];
        logic [63:0] addr;
        logic [63:0] tag;
        logic [63:0] adj;
        logic [1:0]  kind;
        logic [7:0]  key;
        int n;
        int r;
        int d;
        n = active_slots();
        tag_pool[0] = 64'd0;
        tag_pool[1] = rand64();
        tag_pool[2] = 64'($urandom_range(1, 9));
        tag_pool[3] = ($urandom_range(0, 1) != 0) ? TAG_MIN : ALL_ONES;
        src_steady = ($urandom_range(0, 3) == 0);
        sink_steady = ($urandom_range(0, 3) == 0);
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 35)
                kind = KIND_INSERT;
            else if (r < 60)
                kind = KIND_GET;
            else if (r < 80)
                kind = KIND_REMOVE;
            else
                kind = KIND_READJUST;
            r = $urandom_range(0, 99);
            if (r < 10)
                addr = 64'd0;
            else if (r < 20)
                addr = 64'($urandom_range(1, 15));
            else
                addr = rand64();
            tag = ($urandom_range(0, 99) < 75) ? tag_pool[$urandom_range(0, 3)] : rand64();
            if ($urandom_range(0, 99) < 80)
                key = 8'($urandom_range(0, (n + 1 > 255) ? 255 : n + 1));
            else
                key = 8'($urandom_range(0, 255));
            if ($urandom_range(0, 99) < 30) begin
                d = $urandom_range(0, 32) - 16;
                adj = {{32{d[31]}}, d};
            end else begin
                adj = rand64();
            end
            queue_op(kind, addr, tag, key, adj);
        end
    endtask

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        int limits[9];
        int p;
        foreach (slot_addr[i]) begin
            slot_addr[i] = 64'd0;
            slot_tag[i] = 64'd0;
        end
        limits = '{1, 3, 8, 0, 17, 256, 511, 300, 0};
        limits[8] = $urandom_range(2, 64);
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // no active slots after reset
        queue_op(KIND_INSERT, 64'h11, 64'd3, 8'd0, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd0, 64'd0);
        queue_op(KIND_REMOVE, 64'd0, 64'd0, 8'd0, 64'd0);
        queue_op(KIND_READJUST, 64'd0, 64'd0, 8'd0, 64'd1);
        drain();

        write_slot_limit(9'd4);
        queue_op(KIND_INSERT, ALL_ONES, TAG_MIN, 8'd0, 64'd0);
        queue_op(KIND_INSERT, 64'd0, 64'd5, 8'd0, 64'd0);
        queue_op(KIND_INSERT, 64'd1, TAG_MAX, 8'd0, 64'd0);
        queue_op(KIND_INSERT, 64'h0123_4567_89ab_cdef, ALL_ONES, 8'd0, 64'd0);
        queue_op(KIND_INSERT, 64'hfedc_ba98_7654_3210, 64'd7, 8'd0, 64'd0);
        queue_op(KIND_INSERT, 64'd2, 64'd9, 8'd0, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd0, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd3, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd4, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd255, 64'd0);
        queue_op(KIND_REMOVE, 64'd0, 64'd0, 8'd255, 64'd0);
        queue_op(KIND_REMOVE, 64'd0, 64'd0, 8'd2, 64'd0);
        // tag 0 also hits the freed slot
        queue_op(KIND_READJUST, 64'd0, 64'd0, 8'd0, 64'd5);
        queue_op(KIND_READJUST, 64'd0, TAG_MIN, 8'd0, TAG_MIN);
        queue_op(KIND_READJUST, 64'd0, TAG_MAX, 8'd0, ALL_ONES);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd1, 64'd0);
        queue_op(KIND_GET, 64'd0, 64'd0, 8'd2, 64'd0);
        queue_op(KIND_INSERT, 64'd3, 64'd0, 8'd0, 64'd0);
        drain();

        for (p = 0; p < 9; p++) begin
            write_slot_limit(9'(limits[p]));
            random_ops(84);
            drain();
        end

        repeat (8) @(posedge aclk);
        if (err_count == 0 && predicted_replies.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
